FILE: hw/rtl/tce_pkg.sv
package tce_pkg;

  localparam int SYM_W      = 5;
  localparam int MAX_PERIOD = 16;
  localparam int CNT_W      = $clog2(MAX_PERIOD + 1);
  localparam int ADDR_W     = $clog2(MAX_PERIOD);
  localparam int TRIPLE_W   = 6;
  localparam int NUM_LAYERS = 3;
  localparam int LAYER_W    = 45;
  localparam int CFG_IDX_W  = 3;
  localparam int TDATA_W    = 8;

  localparam logic [CNT_W-1:0] PERIOD_RESET = CNT_W'(5);

  // Digit positions within a triple, in the order the line is built.
  localparam logic [1:0] DIG_LAYER = 2'd0;
  localparam logic [1:0] DIG_ROW   = 2'd1;
  localparam logic [1:0] DIG_COL   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECRYPT_MODE = 3'd0,
    CFG_PERIOD       = 3'd1,
    CFG_LAYER0       = 3'd2,
    CFG_LAYER1       = 3'd3,
    CFG_LAYER2       = 3'd4
  } cfg_idx_t;

  typedef logic [NUM_LAYERS-1:0][LAYER_W-1:0] key_t;

  // A line position held as quotient and remainder by three.
  typedef struct packed {
    logic [ADDR_W-1:0] quo;
    logic [1:0]        rem;
  } dm_t;

  function automatic dm_t dm_add1(input dm_t v);
    dm_t r;
    r = v;
    if (v.rem == 2'd2) begin
      r.rem = 2'd0;
      r.quo = v.quo + ADDR_W'(1);
    end else begin
      r.rem = v.rem + 2'd1;
    end
    return r;
  endfunction

  function automatic dm_t dm_add2(input dm_t v);
    dm_t r;
    r = v;
    if (v.rem == 2'd0) begin
      r.rem = 2'd2;
    end else begin
      r.rem = v.rem - 2'd1;
      r.quo = v.quo + ADDR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [1:0] mod3(input logic [1:0] v);
    return (v == 2'd3) ? 2'd0 : v;
  endfunction

  // First layer holding the symbol wins; within it the last match in row-major order.
  function automatic logic [TRIPLE_W-1:0] lookup_triple(input key_t key,
                                                        input logic [SYM_W-1:0] sym);
    logic [TRIPLE_W-1:0] res;
    logic                found;
    logic [1:0]          hit_row;
    logic [1:0]          hit_col;
    res = '0;
    for (int l = NUM_LAYERS - 1; l >= 0; l--) begin
      found   = 1'b0;
      hit_row = 2'd0;
      hit_col = 2'd0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (key[l][SYM_W*(3*r+c) +: SYM_W] == sym) begin
            found   = 1'b1;
            hit_row = 2'(r);
            hit_col = 2'(c);
          end
        end
      end
      if (found) begin
        res = {2'(l), hit_row, hit_col};
      end
    end
    return res;
  endfunction

  function automatic logic [SYM_W-1:0] key_symbol(input key_t key, input logic [1:0] lay,
                                                  input logic [1:0] row, input logic [1:0] col);
    logic [1:0] l;
    logic [3:0] pos;
    l   = mod3(lay);
    pos = 4'(mod3(row)) * 4'd3 + 4'(mod3(col));
    return key[l][SYM_W*pos +: SYM_W];
  endfunction

endpackage

FILE: hw/rtl/tce_ram.sv
module tce_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/trifid_cipher_engine_unit.sv
// A group of n symbols takes n input beats. After the beat that completes or ends the group, the
// results leave one by one, three memory reads each (one per digit); a held output stalls the reads.
// The single read port of the triple memory sets the pace; no input is taken while a group is emitted.
// Reset: synchronous, active low; clears the control state and the configuration registers
// (period 5, all else 0). The triple memory is not cleared: only entries of the current group are read.
module trifid_cipher_engine_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tce_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tce_pkg::LAYER_W-1:0]         cfg_data,
  // Input symbols.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tce_pkg::TDATA_W-1:0]         in_tdata,   // [4:0] in_symbol, [7:5] zero
  input  logic                                in_tlast,   // in_message_end
  // Result symbols.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tce_pkg::TDATA_W-1:0]         out_tdata,  // [4:0] out_symbol, [7:5] zero
  output logic                                out_tlast,  // out_group_last
  output logic                                out_tuser   // out_message_end
);

  // The engine alternates between collecting a group and emitting it.
  typedef enum logic [1:0] {
    ST_FILL = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  // Configuration registers.
  logic                          decrypt_r;
  logic [tce_pkg::CNT_W-1:0]     period_r;
  tce_pkg::key_t                 key_r;

  // Collection state.
  state_t                        state_r, state_nxt;
  logic [tce_pkg::CNT_W-1:0]     count_r, count_nxt;
  tce_pkg::dm_t                  c1_r, c1_nxt;      // count split by three
  tce_pkg::dm_t                  c2_r, c2_nxt;      // twice count split by three
  logic [tce_pkg::ADDR_W-1:0]    n_m1_r, n_m1_nxt;  // group size less one
  logic                          msg_end_r, msg_end_nxt;

  // Read issue state.
  logic [tce_pkg::ADDR_W-1:0]    k_r, k_nxt;
  logic [1:0]                    d_r, d_nxt;
  logic [tce_pkg::ADDR_W-1:0]    e_idx_r, e_idx_nxt;
  logic [1:0]                    e_plane_r, e_plane_nxt;
  tce_pkg::dm_t [2:0]            ptr_r, ptr_nxt;
  logic                          issue_done_r, issue_done_nxt;

  // Read data stage.
  logic                          dv_r, dv_nxt;
  logic [1:0]                    dd_r, dd_nxt;
  logic [1:0]                    dsel_r, dsel_nxt;
  logic                          dlast_r, dlast_nxt;
  logic [1:0]                    dig0_r, dig0_nxt;
  logic [1:0]                    dig1_r, dig1_nxt;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic [tce_pkg::SYM_W-1:0]     out_sym_r, out_sym_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_end_r, out_end_nxt;

  // Combinational helpers.
  logic                          in_acc;
  logic [tce_pkg::CNT_W-1:0]     cnt_inc;
  logic [tce_pkg::CNT_W-1:0]     eff_period;
  logic                          flush;
  logic                          adv;
  logic                          issuing;
  logic                          rd_en;
  logic [tce_pkg::ADDR_W-1:0]    rd_addr;
  logic [1:0]                    rd_sel;
  logic [tce_pkg::TRIPLE_W-1:0]  wr_triple;
  logic [tce_pkg::TRIPLE_W-1:0]  rd_triple;
  logic [1:0]                    rd_digit;
  logic                          last_issue;
  tce_pkg::dm_t                  dec_ptr;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_FILL);
  assign in_acc     = in_tvalid && in_tready;
  assign cnt_inc    = count_r + tce_pkg::CNT_W'(1);

  // A zero period acts as one; anything above the buffer depth saturates.
  always_comb begin
    if (period_r == '0) begin
      eff_period = tce_pkg::CNT_W'(1);
    end else if (period_r > tce_pkg::CNT_W'(tce_pkg::MAX_PERIOD)) begin
      eff_period = tce_pkg::CNT_W'(tce_pkg::MAX_PERIOD);
    end else begin
      eff_period = period_r;
    end
  end

  assign flush     = in_acc && ((cnt_inc >= eff_period) || in_tlast);
  assign wr_triple = tce_pkg::lookup_triple(key_r, in_tdata[tce_pkg::SYM_W-1:0]);

  // The whole read pipeline moves only when the output register can take a result.
  assign adv     = !out_valid_r || out_tready;
  assign issuing = (state_r == ST_EMIT) && !issue_done_r;
  assign rd_en   = issuing && adv;

  always_comb begin
    case (d_r)
      tce_pkg::DIG_LAYER: dec_ptr = ptr_r[0];
      tce_pkg::DIG_ROW:   dec_ptr = ptr_r[1];
      tce_pkg::DIG_COL:   dec_ptr = ptr_r[2];
      default:            dec_ptr = ptr_r[0];
    endcase
  end

  // Encryption walks the line of layers, rows, columns in order; decryption reads
  // position k, n + k and 2n + k of the line built triple by triple.
  assign rd_addr    = decrypt_r ? dec_ptr.quo : e_idx_r;
  assign rd_sel     = decrypt_r ? dec_ptr.rem : e_plane_r;
  assign last_issue = (k_r == n_m1_r) && (d_r == tce_pkg::DIG_COL);

  tce_ram #(
    .WIDTH (tce_pkg::TRIPLE_W),
    .DEPTH (tce_pkg::MAX_PERIOD)
  ) u_triple_ram (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (count_r[tce_pkg::ADDR_W-1:0]),
    .wr_data (wr_triple),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_triple)
  );

  always_comb begin
    case (dsel_r)
      tce_pkg::DIG_LAYER: rd_digit = rd_triple[5:4];
      tce_pkg::DIG_ROW:   rd_digit = rd_triple[3:2];
      tce_pkg::DIG_COL:   rd_digit = rd_triple[1:0];
      default:            rd_digit = 2'd0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    c1_nxt         = c1_r;
    c2_nxt         = c2_r;
    n_m1_nxt       = n_m1_r;
    msg_end_nxt    = msg_end_r;
    k_nxt          = k_r;
    d_nxt          = d_r;
    e_idx_nxt      = e_idx_r;
    e_plane_nxt    = e_plane_r;
    ptr_nxt        = ptr_r;
    issue_done_nxt = issue_done_r;
    dv_nxt         = dv_r;
    dd_nxt         = dd_r;
    dsel_nxt       = dsel_r;
    dlast_nxt      = dlast_r;
    dig0_nxt       = dig0_r;
    dig1_nxt       = dig1_r;
    out_valid_nxt  = out_valid_r;
    out_sym_nxt    = out_sym_r;
    out_last_nxt   = out_last_r;
    out_end_nxt    = out_end_r;

    // Collection: count the beat and keep the running splits by three for decryption; the closing beat starts the emit.
    if (flush) begin
      state_nxt      = ST_EMIT;
      count_nxt      = '0;
      c1_nxt         = '0;
      c2_nxt         = '0;
      n_m1_nxt       = cnt_inc[tce_pkg::ADDR_W-1:0] - tce_pkg::ADDR_W'(1);
      msg_end_nxt    = in_tlast;
      k_nxt          = '0;
      d_nxt          = tce_pkg::DIG_LAYER;
      e_idx_nxt      = '0;
      e_plane_nxt    = tce_pkg::DIG_LAYER;
      ptr_nxt[0]     = '0;
      ptr_nxt[1]     = tce_pkg::dm_add1(c1_r);
      ptr_nxt[2]     = tce_pkg::dm_add2(c2_r);
      issue_done_nxt = 1'b0;
    end else if (in_acc) begin
      count_nxt = cnt_inc;
      c1_nxt    = tce_pkg::dm_add1(c1_r);
      c2_nxt    = tce_pkg::dm_add2(c2_r);
    end

    if (adv) begin
      // Issue stage: one digit read per cycle while the output register can take a result.
      dv_nxt    = issuing;
      dd_nxt    = d_r;
      dsel_nxt  = rd_sel;
      dlast_nxt = last_issue;
      if (issuing) begin
        if (e_idx_r == n_m1_r) begin
          e_idx_nxt   = '0;
          e_plane_nxt = e_plane_r + 2'd1;
        end else begin
          e_idx_nxt = e_idx_r + tce_pkg::ADDR_W'(1);
        end
        if (d_r == tce_pkg::DIG_COL) begin
          d_nxt      = tce_pkg::DIG_LAYER;
          k_nxt      = k_r + tce_pkg::ADDR_W'(1);
          ptr_nxt[0] = tce_pkg::dm_add1(ptr_r[0]);
          ptr_nxt[1] = tce_pkg::dm_add1(ptr_r[1]);
          ptr_nxt[2] = tce_pkg::dm_add1(ptr_r[2]);
        end else begin
          d_nxt = d_r + 2'd1;
        end
        if (last_issue) begin
          issue_done_nxt = 1'b1;
        end
      end

      // Data stage: gather the digits; the third one completes a result.
      out_valid_nxt = 1'b0;
      if (dv_r) begin
        case (dd_r)
          tce_pkg::DIG_LAYER: dig0_nxt = rd_digit;
          tce_pkg::DIG_ROW:   dig1_nxt = rd_digit;
          tce_pkg::DIG_COL: begin
            out_valid_nxt = 1'b1;
            out_sym_nxt   = tce_pkg::key_symbol(key_r, dig0_r, dig1_r, rd_digit);
            out_last_nxt  = dlast_r;
            out_end_nxt   = dlast_r && msg_end_r;
            if (dlast_r) begin
              state_nxt = ST_FILL;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_r    <= 1'b0;
      period_r     <= tce_pkg::PERIOD_RESET;
      key_r        <= '0;
      state_r      <= ST_FILL;
      count_r      <= '0;
      c1_r         <= '0;
      c2_r         <= '0;
      issue_done_r <= 1'b1;
      dv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tce_pkg::CFG_DECRYPT_MODE: decrypt_r <= cfg_data[0];
          tce_pkg::CFG_PERIOD:       period_r  <= cfg_data[tce_pkg::CNT_W-1:0];
          tce_pkg::CFG_LAYER0:       key_r[0]  <= cfg_data;
          tce_pkg::CFG_LAYER1:       key_r[1]  <= cfg_data;
          tce_pkg::CFG_LAYER2:       key_r[2]  <= cfg_data;
          default: ;
        endcase
      end
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      c1_r         <= c1_nxt;
      c2_r         <= c2_nxt;
      issue_done_r <= issue_done_nxt;
      dv_r         <= dv_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload and sequencing registers, all loaded before use.
  always_ff @(posedge clk) begin
    n_m1_r    <= n_m1_nxt;
    msg_end_r <= msg_end_nxt;
    k_r       <= k_nxt;
    d_r       <= d_nxt;
    e_idx_r   <= e_idx_nxt;
    e_plane_r <= e_plane_nxt;
    ptr_r     <= ptr_nxt;
    dd_r      <= dd_nxt;
    dsel_r    <= dsel_nxt;
    dlast_r   <= dlast_nxt;
    dig0_r    <= dig0_nxt;
    dig1_r    <= dig1_nxt;
    out_sym_r <= out_sym_nxt;
    out_last_r <= out_last_nxt;
    out_end_r <= out_end_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tce_pkg::TDATA_W'(out_sym_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_end_r;

endmodule

FILE: dv/testbench.sv
module testbench;

  // Pause after the last due result before touching configuration, and the
  // drain allowance at the very end.
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 60;
  localparam int RANDOM_ITEMS  = 360;
  localparam int CYCLE_LIMIT   = 600000;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [tce_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tce_pkg::LAYER_W-1:0]   cfg_data;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [tce_pkg::TDATA_W-1:0]   in_tdata;   // [4:0] in_symbol, [7:5] zero
  logic                          in_tlast;   // in_message_end
  logic                          out_tvalid;
  logic                          out_tready;
  logic [tce_pkg::TDATA_W-1:0]   out_tdata;  // [4:0] out_symbol, [7:5] zero
  logic                          out_tlast;  // out_group_last
  logic                          out_tuser;  // out_message_end

  trifid_cipher_engine_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // One cipher symbol as it should leave the block.
  typedef struct {
    logic [tce_pkg::SYM_W-1:0] symbol;
    logic                      group_last;
    logic                      message_end;
  } cipher_beat_t;

  // Our own copy of the key, the mode and the partly filled group.
  logic                         cfg_decrypt;
  logic [4:0]                   cfg_period;
  tce_pkg::key_t                cfg_key;
  logic [tce_pkg::TRIPLE_W-1:0] held_triple [tce_pkg::MAX_PERIOD];
  int                           held_count;

  // Symbols that the block owes us, oldest first.
  cipher_beat_t cipher_due [$];

  int mismatches;
  int cycle_count;
  bit feed_steady;        // sender offers beats back to back
  bit sink_steady;        // receiver starts no new random stalls
  int sink_hold_request;  // long receiver hold-off, picked up by the sink

  // Mostly no pause or a short one, now and then a long one.
  function automatic int pause_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The first layer that holds the symbol wins; inside that layer the last
  // matching entry in row-major order is taken. A symbol found nowhere maps
  // to layer one, row one, column one.
  function automatic logic [tce_pkg::TRIPLE_W-1:0] locate_symbol(
      input logic [tce_pkg::SYM_W-1:0] sym);
    logic found;
    int   hit;
    for (int l = 0; l < tce_pkg::NUM_LAYERS; l++) begin
      found = 1'b0;
      hit   = 0;
      for (int p = 0; p < 9; p++) begin
        if (cfg_key[l][tce_pkg::SYM_W*p +: tce_pkg::SYM_W] == sym) begin
          found = 1'b1;
          hit   = p;
        end
      end
      if (found) return {2'(l), 2'(hit / 3), 2'(hit % 3)};
    end
    return '0;
  endfunction

  // Takes one accepted symbol into the group. When the group is complete, or
  // the message ends, the digits are laid out in a line and read back the
  // other way round, and the resulting symbols are queued as due.
  function automatic void trifid_absorb(input logic [tce_pkg::SYM_W-1:0] sym,
                                        input logic last);
    logic [1:0]                   digits [3*tce_pkg::MAX_PERIOD];
    logic [tce_pkg::TRIPLE_W-1:0] t;
    logic [1:0]                   lay;
    logic [1:0]                   row;
    logic [1:0]                   col;
    int                           span;
    int                           n;
    cipher_beat_t                 beat;
    span = (cfg_period == 0) ? 1 :
           ((cfg_period > tce_pkg::MAX_PERIOD) ? tce_pkg::MAX_PERIOD : cfg_period);
    if (held_count < tce_pkg::MAX_PERIOD) begin
      held_triple[held_count] = locate_symbol(sym);
      held_count++;
    end
    if (held_count < span && !last) return;
    n = held_count;
    for (int k = 0; k < n; k++) begin
      t = held_triple[k];
      if (!cfg_decrypt) begin
        digits[k]       = t[5:4];
        digits[n + k]   = t[3:2];
        digits[2*n + k] = t[1:0];
      end else begin
        digits[3*k]     = t[5:4];
        digits[3*k + 1] = t[3:2];
        digits[3*k + 2] = t[1:0];
      end
    end
    for (int k = 0; k < n; k++) begin
      if (!cfg_decrypt) begin
        lay = digits[3*k];
        row = digits[3*k + 1];
        col = digits[3*k + 2];
      end else begin
        lay = digits[k];
        row = digits[n + k];
        col = digits[2*n + k];
      end
      beat.symbol      = cfg_key[lay][tce_pkg::SYM_W*(row*3 + col) +: tce_pkg::SYM_W];
      beat.group_last  = (k == n - 1);
      beat.message_end = (k == n - 1) && last;
      cipher_due.push_back(beat);
    end
    held_count = 0;
  endfunction

  // A key holding each of the 27 symbols exactly once.
  function automatic tce_pkg::key_t shuffled_key();
    int            order [27];
    int            j;
    int            swap;
    tce_pkg::key_t k;
    for (int i = 0; i < 27; i++) order[i] = i;
    for (int i = 26; i > 0; i--) begin
      j        = $urandom_range(0, i);
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    k = '0;
    for (int i = 0; i < 27; i++) begin
      k[i / 9][tce_pkg::SYM_W*(i % 9) +: tce_pkg::SYM_W] = tce_pkg::SYM_W'(order[i]);
    end
    return k;
  endfunction

  // Keys that break the permutation rule: a few entries overwritten, so
  // that some symbols repeat and others go missing, or plain random bits.
  function automatic tce_pkg::key_t flawed_key();
    tce_pkg::key_t k;
    if ($urandom_range(0, 2) == 0) begin
      for (int l = 0; l < tce_pkg::NUM_LAYERS; l++) begin
        k[l] = tce_pkg::LAYER_W'({$urandom(), $urandom()});
      end
    end else begin
      k = shuffled_key();
      repeat ($urandom_range(1, 4)) begin
        k[$urandom_range(0, 2)][tce_pkg::SYM_W*$urandom_range(0, 8) +: tce_pkg::SYM_W] =
          tce_pkg::SYM_W'($urandom_range(0, 31));
      end
    end
    return k;
  endfunction

  function automatic void note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("cycle %0d: %s: expected %0d, got %0d", cycle_count, what, want, got);
    end
  endfunction

  // Holds the sender back until the block owes nothing more, then lets it
  // finish any internal work before the next configuration change.
  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cipher_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back; the caller
  // lowers it after the last one.
  task automatic set_reg(input tce_pkg::cfg_idx_t idx,
                         input logic [tce_pkg::LAYER_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tce_pkg::CFG_DECRYPT_MODE: cfg_decrypt = value[0];
      tce_pkg::CFG_PERIOD:       cfg_period  = value[4:0];
      tce_pkg::CFG_LAYER0:       cfg_key[0]  = value;
      tce_pkg::CFG_LAYER1:       cfg_key[1]  = value;
      tce_pkg::CFG_LAYER2:       cfg_key[2]  = value;
      default:                   ;
    endcase
  endtask

  task automatic apply_settings(input logic decrypt, input logic [4:0] period,
                                input tce_pkg::key_t key);
    quiesce();
    set_reg(tce_pkg::CFG_DECRYPT_MODE, tce_pkg::LAYER_W'(decrypt));
    set_reg(tce_pkg::CFG_PERIOD, tce_pkg::LAYER_W'(period));
    set_reg(tce_pkg::CFG_LAYER0, key[0]);
    set_reg(tce_pkg::CFG_LAYER1, key[1]);
    set_reg(tce_pkg::CFG_LAYER2, key[2]);
    cfg_valid <= 1'b0;
  endtask

  // Offers one symbol beat after an optional gap and waits for it to be
  // taken. The valid is left high so the next beat can follow directly.
  task automatic send_symbol(input logic [tce_pkg::SYM_W-1:0] sym, input logic last);
    int gap;
    gap = feed_steady ? 0 : pause_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= tce_pkg::TDATA_W'(sym);
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    trifid_absorb(sym, last);
  endtask

  // Straight after reset: period five and an all-zero key, so every symbol
  // other than zero is missing and zero sits at the last entry of layer one.
  task automatic test_reset_defaults();
    send_symbol(5'd0, 1'b0);
    send_symbol(5'd3, 1'b1);
  endtask

  // Both directions. The encrypt group closes on its third beat together
  // with the message end; the decrypt message ends before its group fills.
  task automatic test_encrypt_and_decrypt();
    apply_settings(1'b0, 5'd3, shuffled_key());
    send_symbol(5'd0, 1'b0);
    send_symbol(5'd26, 1'b0);
    send_symbol(5'd13, 1'b1);
    apply_settings(1'b1, 5'd3, cfg_key);
    send_symbol(5'd5, 1'b0);
    send_symbol(5'd20, 1'b1);
  endtask

  // A period of zero acts as one; a period beyond the buffer saturates.
  task automatic test_period_limits();
    apply_settings(1'b0, 5'd0, shuffled_key());
    send_symbol(5'd7, 1'b0);
    send_symbol(5'd26, 1'b1);
    apply_settings(1'b1, 5'd1, cfg_key);
    send_symbol(5'd1, 1'b0);
    apply_settings(1'b0, 5'd31, cfg_key);
    send_symbol(5'd18, 1'b0);
    send_symbol(5'd9, 1'b1);
  endtask

  // Repeated entries, entries outside the alphabet and symbols that no layer
  // holds. Symbol four sits in layers one and two; layer three is all 31.
  task automatic test_key_quirks();
    tce_pkg::key_t k;
    k = '0;
    for (int p = 0; p < 9; p++) begin
      k[0][tce_pkg::SYM_W*p +: tce_pkg::SYM_W] = 5'd4;
      k[1][tce_pkg::SYM_W*p +: tce_pkg::SYM_W] = tce_pkg::SYM_W'(p + 9);
      k[2][tce_pkg::SYM_W*p +: tce_pkg::SYM_W] = 5'd31;
    end
    k[0][tce_pkg::SYM_W*7 +: tce_pkg::SYM_W] = 5'd9;
    k[1][tce_pkg::SYM_W*2 +: tce_pkg::SYM_W] = 5'd4;
    k[1][tce_pkg::SYM_W*5 +: tce_pkg::SYM_W] = 5'd4;
    apply_settings(1'b0, 5'd4, k);
    send_symbol(5'd4, 1'b0);
    send_symbol(5'd9, 1'b0);
    send_symbol(5'd31, 1'b0);
    send_symbol(5'd27, 1'b1);
  endtask

  // Three symbols wait in a group of six when the period drops to two: the
  // next beat must flush all four at once.
  task automatic test_period_lowered();
    apply_settings(1'b0, 5'd6, shuffled_key());
    send_symbol(5'd2, 1'b0);
    send_symbol(5'd25, 1'b0);
    send_symbol(5'd11, 1'b0);
    quiesce();
    set_reg(tce_pkg::CFG_PERIOD, tce_pkg::LAYER_W'(5'd2));
    cfg_valid <= 1'b0;
    send_symbol(5'd16, 1'b0);
  endtask

  // The sink holds off for a long stretch while full groups are offered
  // back to back, so the block fills up and refuses input; afterwards the
  // sender waits for every due symbol before going on.
  task automatic test_backpressure();
    apply_settings(1'b0, 5'(tce_pkg::MAX_PERIOD), shuffled_key());
    sink_hold_request = 400;
    feed_steady = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_symbol(tce_pkg::SYM_W'($urandom_range(0, 26)), i == 39);
    end
    feed_steady = 1'b0;
    quiesce();
  endtask

  // Phases of random settings, each carrying a few messages of random
  // symbols. Most messages end properly; a few run on so that a partial
  // group meets the next set of registers.
  task automatic test_random_traffic();
    int                        sent;
    int                        len;
    int                        pick;
    logic [4:0]                period;
    logic [tce_pkg::SYM_W-1:0] sym;
    bit                        closes;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) period = 5'd0;
      else if (pick <= 3) period = 5'($urandom_range(tce_pkg::MAX_PERIOD + 1, 31));
      else if (pick <= 6) period = 5'(tce_pkg::MAX_PERIOD);
      else period = 5'($urandom_range(1, tce_pkg::MAX_PERIOD - 1));
      apply_settings(1'($urandom_range(0, 1)), period,
                     ($urandom_range(0, 9) < 7) ? shuffled_key() : flawed_key());
      feed_steady = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 3)) begin
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 12);
        closes = ($urandom_range(0, 9) != 0) || (sent + len >= RANDOM_ITEMS);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) sym = tce_pkg::SYM_W'($urandom_range(27, 31));
          else sym = tce_pkg::SYM_W'($urandom_range(0, 26));
          send_symbol(sym, closes && (i == len - 1));
        end
        sent += len;
      end
      feed_steady = 1'b0;
    end
  endtask

  // Result sink: random short and long stalls, calm stretches, and the long
  // hold-off that the backpressure test asks for, counted down here.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_request > 0) begin
        hold_left         = sink_hold_request;
        sink_hold_request = 0;
      end
      if ($urandom_range(0, 149) == 0) sink_steady = !sink_steady;
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 3) == 0) stall_left = pause_length();
      end
    end
  end

  // Every symbol beat taken from the block is compared with the oldest one
  // due. Values are read just after the edge, before the block updates them.
  always @(posedge clk) begin : result_check
    cipher_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_due.size() == 0) begin
        note_mismatch("symbol with none due", -1, out_tdata);
      end else begin
        want = cipher_due.pop_front();
        if (out_tdata !== tce_pkg::TDATA_W'(want.symbol)) begin
          note_mismatch("out_symbol", want.symbol, out_tdata);
        end
        if (out_tlast !== want.group_last) begin
          note_mismatch("out_group_last", want.group_last, out_tlast);
        end
        if (out_tuser !== want.message_end) begin
          note_mismatch("out_message_end", want.message_end, out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = tce_pkg::CFG_DECRYPT_MODE;
    cfg_data          = '0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    in_tlast          = 1'b0;
    mismatches        = 0;
    cycle_count       = 0;
    feed_steady       = 1'b0;
    sink_steady       = 1'b0;
    sink_hold_request = 0;
    // Register state after reset, mirrored.
    cfg_decrypt = 1'b0;
    cfg_period  = tce_pkg::PERIOD_RESET;
    cfg_key     = '0;
    held_count  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_encrypt_and_decrypt();
    test_period_limits();
    test_key_quirks();
    test_period_lowered();
    test_backpressure();
    test_random_traffic();

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cipher_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: trifid_cipher_engine_unit.f
hw/rtl/tce_pkg.sv
hw/rtl/tce_ram.sv
hw/rtl/trifid_cipher_engine_unit.sv
dv/testbench.sv
